// File: rtl/core/pair_term_stack_machine_unit_macros.svh
`ifndef PAIR_TERM_STACK_MACHINE_UNIT_MACROS_SVH
`define PAIR_TERM_STACK_MACHINE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PTSM_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("%m: check failed");
`define PTSM_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("%m: check failed");
`else
`define PTSM_ASSERT_IMP(label, clk, rst, a, c)
`define PTSM_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// File: rtl/core/ptsm_pkg.sv
package ptsm_pkg;
   localparam int PROGRAM_DEPTH = 4096;
   localparam int CELL_DEPTH = 16384;
   localparam int STACK_DEPTH = 8192;
   localparam int BINDING_DEPTH = 65536;
   localparam int MAX_VARIABLES = 24;
   localparam int PA_W = 12;
   localparam int CA_W = 14;
   localparam int SA_W = 13;
   localparam int BA_W = 16;
   localparam logic [24:0] STEP_LIMIT = 25'd16777216;

   localparam logic [15:0] T_UNIT = 16'h4000;
   localparam logic [15:0] T_ZERO = 16'h8000;
   localparam logic [15:0] T_ONE = 16'hC000;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_RUN = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_CELLS = 2'd1;
   localparam logic [1:0] ST_STACK = 2'd2;
   localparam logic [1:0] ST_OPCODE = 2'd3;

   localparam logic [15:0] OP_RET = 16'd0;
   localparam logic [15:0] OP_SPLIT = 16'd1;
   localparam logic [15:0] OP_BIND = 16'd2;
   localparam logic [15:0] OP_UBIND = 16'd3;
   localparam logic [15:0] OP_MATCH = 16'd4;
   localparam logic [15:0] OP_PUNIT = 16'd5;
   localparam logic [15:0] OP_PZERO = 16'd6;
   localparam logic [15:0] OP_PONE = 16'd7;
   localparam logic [15:0] OP_PVAR = 16'd8;
   localparam logic [15:0] OP_PAIR = 16'd9;
   localparam logic [15:0] OP_CALL = 16'd10;
   localparam logic [15:0] OP_TAIL = 16'd11;
   localparam logic [15:0] OP_RET2 = 16'd12;
endpackage

// File: rtl/core/pair_term_stack_machine_unit.sv
// channel | direction | signals
// req     | in        | req_valid, req_ready, req_action .. req_cell_address
// rsp     | out       | rsp_valid, rsp_ready, rsp_result_term .. rsp_unit_count
// A write gives no transaction; a read passes through S_RDC and S_RDC2 to S_OUT.
// A run fetches each word from program memory (one registered read port):
// each instruction passes S_FETCH, S_DEC, S_MEM and S_EXE; match and push
// variable add S_OPND for the operand, and a return into a caller adds S_EXE2.
// After reset a sweep over all CELL_DEPTH entries fills the free stack; req_ready is low.
// A result waits in the output register; the next request is taken only then.
`include "pair_term_stack_machine_unit_macros.svh"
module pair_term_stack_machine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_program_address,
   input  logic [15:0] req_program_word,
   input  logic [11:0] req_entry_address,
   input  logic [13:0] req_cell_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_result_term,
   output logic [31:0] rsp_cell_word,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_call_count,
   output logic [31:0] rsp_bind_count,
   output logic [31:0] rsp_match_count,
   output logic [31:0] rsp_split_count,
   output logic [31:0] rsp_unit_count
);
   import ptsm_pkg::*;

   typedef enum logic [11:0] {
      S_INIT  = 12'b000000000001,
      S_IDLE  = 12'b000000000010,
      S_RDC   = 12'b000000000100,
      S_RDC2  = 12'b000000001000,
      S_FETCH = 12'b000000010000,
      S_DEC   = 12'b000000100000,
      S_OPND  = 12'b000001000000,
      S_MEM   = 12'b000010000000,
      S_EXE   = 12'b000100000000,
      S_EXE2  = 12'b001000000000,
      S_DONE  = 12'b010000000000,
      S_OUT   = 12'b100000000000
   } state_type;

   state_type   state_ff;
   logic [15:0] prog_mem [PROGRAM_DEPTH];
   logic [31:0] cell_mem [CELL_DEPTH];
   logic [CA_W-1:0] free_mem [CELL_DEPTH];
   logic [15:0] val_mem  [STACK_DEPTH];
   logic [15:0] pend_mem [STACK_DEPTH];
   logic [11:0] ret_mem  [STACK_DEPTH];
   logic [33:0] frm_mem  [STACK_DEPTH];
   logic [15:0] bind_mem [BINDING_DEPTH];

   logic [15:0] prog_q, pend_q, val_q, val2_q, bind_q;
   logic [31:0] cell_q;
   logic [33:0] frm_q;
   logic [11:0] ret_q;
   logic [CA_W-1:0] free_q;

   logic [CA_W:0] free_cnt_ff;
   logic [CA_W:0] init_ff;
   logic [11:0] pc_ff;
   logic [15:0] term_ff, op_ff, opnd_ff;
   logic [SA_W:0] vsp_ff, psp_ff, csp_ff;
   logic [16:0] base_ff, top_ff;
   logic [24:0] steps_ff;
   logic [31:0] cnt_ff [5];
   logic [15:0] res_ff;
   logic [31:0] word_ff;
   logic [1:0]  stat_ff;

   logic [11:0] prog_ra;
   logic [16:0] vaddr;
   logic match_take;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_result_term = res_ff;
   assign rsp_cell_word = word_ff;
   assign rsp_status = stat_ff;
   assign rsp_call_count = cnt_ff[0];
   assign rsp_bind_count = cnt_ff[1];
   assign rsp_match_count = cnt_ff[2];
   assign rsp_split_count = cnt_ff[3];
   assign rsp_unit_count = cnt_ff[4];
   assign prog_ra = pc_ff;
   assign vaddr = {1'b0, opnd_ff} + base_ff;
   assign match_take = (term_ff == T_ONE);

   always_ff @(posedge clock) begin
      prog_q <= prog_mem[prog_ra];
      cell_q <= cell_mem[(state_ff == S_IDLE) ? req_cell_address : term_ff[CA_W-1:0]];
      free_q <= free_mem[free_cnt_ff[CA_W-1:0] - 1'b1];
      val_q  <= val_mem[vsp_ff[SA_W-1:0] - 1'b1];
      val2_q <= val_mem[vsp_ff[SA_W-1:0] - 2'd2];
      pend_q <= pend_mem[psp_ff[SA_W-1:0] - 1'b1];
      ret_q  <= ret_mem[csp_ff[SA_W-1:0] - 1'b1];
      frm_q  <= frm_mem[csp_ff[SA_W-1:0] - 1'b1];
      bind_q <= bind_mem[vaddr[BA_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid && req_action == ACT_WRITE)
         prog_mem[req_program_address] <= req_program_word;
      if (state_ff == S_INIT)
         free_mem[init_ff[CA_W-1:0]] <= CA_W'(CELL_DEPTH - 1) - init_ff[CA_W-1:0];
      if (state_ff == S_EXE) begin
         unique case (op_ff)
            OP_SPLIT: begin
               if (psp_ff < (SA_W+1)'(STACK_DEPTH))
                  pend_mem[psp_ff[SA_W-1:0]] <= (term_ff < 16'(CELL_DEPTH)) ?
                     cell_q[31:16] : 16'd0;
               if (term_ff < 16'(CELL_DEPTH) && free_cnt_ff < (CA_W+1)'(CELL_DEPTH))
                  free_mem[free_cnt_ff[CA_W-1:0]] <= term_ff[CA_W-1:0];
            end
            OP_BIND:
               if (top_ff < 17'(BINDING_DEPTH)) bind_mem[top_ff[BA_W-1:0]] <= term_ff;
            OP_PUNIT, OP_PZERO, OP_PONE:
               val_mem[vsp_ff[SA_W-1:0]] <= (op_ff == OP_PUNIT) ? T_UNIT :
                  (op_ff == OP_PZERO) ? T_ZERO : T_ONE;
            OP_PVAR:
               val_mem[vsp_ff[SA_W-1:0]] <= (vaddr < 17'(BINDING_DEPTH)) ? bind_q : 16'd0;
            OP_PAIR:
               if (vsp_ff >= 2 && free_cnt_ff != 0) begin
                  cell_mem[free_q] <= {val_q, val2_q};
                  val_mem[vsp_ff[SA_W-1:0] - 2'd2] <= {2'b00, free_q};
               end
            OP_CALL:
               if (csp_ff < (SA_W+1)'(STACK_DEPTH)) begin
                  ret_mem[csp_ff[SA_W-1:0]] <= pc_ff;
                  frm_mem[csp_ff[SA_W-1:0]] <= {top_ff, base_ff};
               end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff <= '0;
         free_cnt_ff <= (CA_W+1)'(CELL_DEPTH - 1);
         for (int i = 0; i < 5; i++) cnt_ff[i] <= '0;
      end else begin
         unique case (state_ff)
            S_INIT: begin
               init_ff <= init_ff + 1'b1;
               if (init_ff == (CA_W+1)'(CELL_DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE:
               if (req_valid) begin
                  if (req_action == ACT_RUN) begin
                     pc_ff <= req_entry_address;
                     term_ff <= '0; vsp_ff <= '0; psp_ff <= '0; csp_ff <= '0;
                     base_ff <= '0; top_ff <= '0; steps_ff <= '0;
                     state_ff <= S_FETCH;
                  end else if (req_action == ACT_READ) begin
                     state_ff <= S_RDC;
                  end
               end
            S_RDC: begin
               word_ff <= cell_q;
               state_ff <= S_RDC2;
            end
            S_RDC2: begin
               res_ff <= '0; stat_ff <= ST_OK;
               state_ff <= S_OUT;
            end
            S_FETCH: begin
               if (steps_ff == STEP_LIMIT) begin
                  res_ff <= '0; stat_ff <= ST_STACK; state_ff <= S_DONE;
               end else begin
                  steps_ff <= steps_ff + 1'b1;
                  pc_ff <= pc_ff + 1'b1;
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               op_ff <= prog_q;
               if (prog_q == OP_MATCH || prog_q == OP_PVAR) begin
                  pc_ff <= pc_ff + 1'b1;
                  state_ff <= S_OPND;
               end else state_ff <= S_MEM;
            end
            S_OPND: begin
               opnd_ff <= prog_q;
               state_ff <= S_MEM;
            end
            S_MEM: state_ff <= S_EXE;
            S_EXE: begin
               state_ff <= S_FETCH;
               unique case (op_ff)
                  OP_SPLIT:
                     if (psp_ff >= (SA_W+1)'(STACK_DEPTH)) begin
                        stat_ff <= ST_STACK; state_ff <= S_DONE;
                     end else begin
                        cnt_ff[3] <= cnt_ff[3] + 1'b1;
                        psp_ff <= psp_ff + 1'b1;
                        term_ff <= (term_ff < 16'(CELL_DEPTH)) ? cell_q[15:0] : 16'd0;
                        if (term_ff < 16'(CELL_DEPTH) &&
                            free_cnt_ff < (CA_W+1)'(CELL_DEPTH))
                           free_cnt_ff <= free_cnt_ff + 1'b1;
                     end
                  OP_BIND:
                     if (top_ff >= 17'(BINDING_DEPTH)) begin
                        stat_ff <= ST_STACK; state_ff <= S_DONE;
                     end else begin
                        cnt_ff[1] <= cnt_ff[1] + 1'b1;
                        top_ff <= top_ff + 1'b1;
                        if (psp_ff != 0) begin
                           term_ff <= pend_q; psp_ff <= psp_ff - 1'b1;
                        end
                     end
                  OP_UBIND: begin
                     cnt_ff[4] <= cnt_ff[4] + 1'b1;
                     if (psp_ff != 0) begin
                        term_ff <= pend_q; psp_ff <= psp_ff - 1'b1;
                     end
                  end
                  OP_MATCH: begin
                     cnt_ff[2] <= cnt_ff[2] + 1'b1;
                     if (match_take) pc_ff <= pc_ff + opnd_ff[11:0];
                     if (psp_ff != 0) begin
                        term_ff <= pend_q; psp_ff <= psp_ff - 1'b1;
                     end
                  end
                  OP_PUNIT, OP_PZERO, OP_PONE:
                     if (vsp_ff >= (SA_W+1)'(STACK_DEPTH)) begin
                        stat_ff <= ST_STACK; state_ff <= S_DONE;
                     end else vsp_ff <= vsp_ff + 1'b1;
                  OP_PVAR:
                     if (opnd_ff >= 16'(MAX_VARIABLES)) begin
                        stat_ff <= ST_OPCODE; state_ff <= S_DONE;
                     end else if (vsp_ff >= (SA_W+1)'(STACK_DEPTH)) begin
                        stat_ff <= ST_STACK; state_ff <= S_DONE;
                     end else vsp_ff <= vsp_ff + 1'b1;
                  OP_PAIR:
                     if (vsp_ff < 2) begin
                        stat_ff <= ST_STACK; state_ff <= S_DONE;
                     end else if (free_cnt_ff == 0) begin
                        stat_ff <= ST_CELLS; state_ff <= S_DONE;
                     end else begin
                        free_cnt_ff <= free_cnt_ff - 1'b1;
                        vsp_ff <= vsp_ff - 1'b1;
                     end
                  OP_CALL:
                     if (vsp_ff == 0 || csp_ff >= (SA_W+1)'(STACK_DEPTH)) begin
                        stat_ff <= ST_STACK; state_ff <= S_DONE;
                     end else begin
                        cnt_ff[0] <= cnt_ff[0] + 1'b1;
                        term_ff <= val_q; vsp_ff <= vsp_ff - 1'b1;
                        csp_ff <= csp_ff + 1'b1;
                        base_ff <= top_ff;
                        pc_ff <= '0; psp_ff <= '0;
                     end
                  OP_TAIL:
                     if (vsp_ff == 0) begin
                        stat_ff <= ST_STACK; state_ff <= S_DONE;
                     end else begin
                        cnt_ff[0] <= cnt_ff[0] + 1'b1;
                        term_ff <= val_q; vsp_ff <= vsp_ff - 1'b1;
                        top_ff <= base_ff;
                        pc_ff <= '0; psp_ff <= '0;
                     end
                  OP_RET, OP_RET2:
                     if (vsp_ff == 0) begin
                        stat_ff <= ST_STACK; state_ff <= S_DONE;
                     end else if (csp_ff == 0) begin
                        res_ff <= val_q; stat_ff <= ST_OK; word_ff <= '0;
                        state_ff <= S_OUT;
                     end else begin
                        csp_ff <= csp_ff - 1'b1;
                        state_ff <= S_EXE2;
                     end
                  default: begin
                     stat_ff <= ST_OPCODE; state_ff <= S_DONE;
                  end
               endcase
            end
            S_EXE2: begin
               top_ff <= frm_q[33:17];
               base_ff <= frm_q[16:0];
               pc_ff <= ret_q;
               state_ff <= S_FETCH;
            end
            S_DONE: begin
               res_ff <= '0; word_ff <= '0;
               state_ff <= S_OUT;
            end
            S_OUT:
               if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_INIT;
         endcase
      end
   end

   `PTSM_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, !rsp_valid)
   `PTSM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PTSM_ASSERT_IMP(a_free_bound, clock, reset, 1'b1, free_cnt_ff <= (CA_W+1)'(CELL_DEPTH))
   `PTSM_ASSERT_NXT(a_write_silent, clock, reset,
      req_valid && req_ready && req_action == ACT_WRITE, !rsp_valid)
endmodule
